// ----- sv/pku_pkg.sv -----
// Package for the particle keyframe update block: widths, opcodes, helpers.
package pku_pkg;

  localparam int KeysDefault = 4;
  localparam int CfgRegs     = 8;
  localparam int CfgIdxW     = 3;

  localparam logic OpStart   = 1'b0;
  localparam logic OpAdvance = 1'b1;

  localparam logic [CfgIdxW-1:0] RegStartMotion = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAccelMotion = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTiming      = 3'd2;
  localparam logic [CfgIdxW-1:0] RegColorLow    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegColorHigh   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegColorTimes  = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSizeKeys    = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSizeTimes   = 3'd7;

  // Divider request and reply between sequencer and divider
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic [15:0] sat16(input logic signed [17:0] v);
    logic [15:0] r;
    if (v > 18'sd32767) r = 16'h7fff;
    else if (v < -18'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- sv/particle_keyframe_update.sv -----
// Top level of the particle keyframe update block: registers, sequencer, datapath.
// One particle, Q8.8 fixed point. A start, or an advance that finds the particle dead,
// goes from idle straight to the output state. A live advance passes through the
// 8 integration steps, the frame decision (with a divide for the sprite frame when
// enabled), tracking for colour and size (each with a divide for its blend factor
// when needed), a colour blend lane by lane and a size blend, then output. The
// sequencer shares the single 32-bit restoring divider (one quotient bit a cycle)
// and the one 18x18 multiplier, which it steps through integration and blending.
// s_axis_tready is high whenever the sequencer is idle; a finished result waits in
// the output register, and the sequencer holds in its output state only if the
// previous result is still untaken.
module particle_keyframe_update #(
  parameter int KEYS = pku_pkg::KeysDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // delta_time, start_x, start_y, start_z
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [127:0] m_axis_tdata, // alive, out_x, out_y, out_z, out_angle,
                                     // out_size, out_frame, out_color, pad
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);
  import pku_pkg::*;

  // sequencer states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StMul   = 4'd1;
  localparam logic [3:0] StFrDiv = 4'd2;
  localparam logic [3:0] StFrWt  = 4'd3;
  localparam logic [3:0] StTrk   = 4'd4;
  localparam logic [3:0] StDivWt = 4'd5;
  localparam logic [3:0] StBlend = 4'd6;
  localparam logic [3:0] StOut   = 4'd7;

  logic [63:0] cfg_q [CfgRegs];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CfgRegs; i++) cfg_q[i] <= '0;
    end else if (cfg_valid_i) begin
      cfg_q[cfg_index_i] <= cfg_data_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  logic [15:0] age_q, age_d;
  logic [15:0] vel_q [3];
  logic [15:0] pos_q [3];
  logic [15:0] avel_q, ang_q;
  logic [1:0]  cidx_q, sidx_q;
  logic        cpend_q, spend_q;
  logic [31:0] ccol_q;
  logic [15:0] csize_q;
  logic [7:0]  frame_q;
  logic        alive_q;
  logic [3:0]  st_q;
  logic [3:0]  step_q;      // multiply step / blend lane
  logic        trk_q;       // 0 colour, 1 size
  logic [15:0] dt_q;
  logic [16:0] fac_q;
  logic [1:0]  ti_q;        // tracking key index
  logic [31:0] acc_q;
  logic        ovalid_q;
  logic [127:0] odata_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  pku_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // key helpers
  function automatic logic [2:0] kcount(input logic [2:0] n);
    return (n > 3'(KEYS)) ? 3'(KEYS) : n;
  endfunction
  logic [2:0] ccnt, scnt;
  assign ccnt = kcount(cfg_q[RegTiming][59:57]);
  assign scnt = kcount(cfg_q[RegTiming][62:60]);

  function automatic logic [31:0] kval(input logic c, input logic [1:0] k,
                                       input logic [63:0] lo, input logic [63:0] hi,
                                       input logic [63:0] sk);
    logic [63:0] w;
    w = k[1] ? hi : lo;
    if (c) return k[0] ? w[63:32] : w[31:0];
    return {16'h0, sk[16*k +: 16]};
  endfunction
  function automatic logic [15:0] ktime(input logic [1:0] k, input logic [47:0] t);
    logic [1:0] j;
    j = k - 2'd1;
    if (k == 2'd0) return 16'h0;
    return t[16*j +: 16];
  endfunction

  // shared multiplier: 18-bit signed by 18-bit signed
  logic signed [17:0] ma, mb;
  logic signed [35:0] mp;
  assign mp = ma * mb;

  logic [47:0] ktimes;
  logic [1:0]  ti1;
  logic [15:0] tl, tn;
  logic [2:0]  tcnt;
  logic [31:0] va, vb;
  assign ktimes = trk_q ? cfg_q[RegSizeTimes][47:0] : cfg_q[RegColorTimes][47:0];
  assign tcnt   = trk_q ? scnt : ccnt;
  assign ti1    = ti_q + 2'd1;
  assign tl     = ktime(ti_q, ktimes);
  assign tn     = ktime(ti1, ktimes);
  assign va = kval(!trk_q, ti_q, cfg_q[RegColorLow], cfg_q[RegColorHigh], cfg_q[RegSizeKeys]);
  assign vb = kval(!trk_q, ti1, cfg_q[RegColorLow], cfg_q[RegColorHigh], cfg_q[RegSizeKeys]);

  // blend operands for current lane
  logic [15:0] la, lb;
  always_comb begin
    if (trk_q) begin
      la = va[15:0];
      lb = vb[15:0];
    end else begin
      la = {8'h0, va[8*step_q[1:0] +: 8]};
      lb = {8'h0, vb[8*step_q[1:0] +: 8]};
    end
  end

  // step select for integration: 0..3 vel/avel by accel, 4..6 pos by vel, 7 angle
  logic [15:0] rate;
  always_comb begin
    rate = '0;
    case (step_q)
      4'd0, 4'd1, 4'd2, 4'd3: rate = cfg_q[RegAccelMotion][16*step_q[1:0] +: 16];
      4'd4: rate = vel_q[0];
      4'd5: rate = vel_q[1];
      4'd6: rate = vel_q[2];
      4'd7: rate = avel_q;
      default: rate = '0;
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (st_q == StMul) begin
      ma = {{2{rate[15]}}, rate};
      mb = {2'b00, dt_q};
    end else if (st_q == StBlend) begin
      ma = {2'b00, lb} - {2'b00, la};
      mb = {1'b0, fac_q};
    end
  end

  // product shifted right by 8, floor; fits 26 bits signed
  logic signed [25:0] stepv;
  logic signed [17:0] sumv;
  assign stepv = mp[33:8];
  always_comb begin
    case (step_q)
      4'd0, 4'd1, 4'd2: sumv = $signed({{2{vel_q[step_q[1:0]][15]}}, vel_q[step_q[1:0]]});
      4'd3:             sumv = $signed({{2{avel_q[15]}}, avel_q});
      4'd4, 4'd5, 4'd6: sumv = $signed({{2{pos_q[step_q[1:0] - 2'd0][15]}},
                                        pos_q[step_q[1:0]]});
      default:          sumv = $signed({{2{ang_q[15]}}, ang_q});
    endcase
  end
  logic signed [26:0] fullsum;
  logic [15:0] satv;
  assign fullsum = 27'(sumv) + 27'(stepv);
  assign satv = (fullsum > 27'sd32767) ? 16'h7fff :
                (fullsum < -27'sd32768) ? 16'h8000 : fullsum[15:0];

  // blended lane = a + ((b-a)*f >> 16), floor
  logic signed [17:0] blendv;
  assign blendv = $signed({2'b00, la}) + 18'(mp[33:16]);

  logic [16:0] agesum;
  assign agesum = {1'b0, age_q} + {1'b0, s_axis_tdata[15:0]};
  assign age_d  = agesum[16] ? 16'hffff : agesum[15:0];

  logic in_fire;
  assign s_axis_tready = (st_q == StIdle);
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // result register loads once the previous result has gone
  logic out_load;
  assign out_load = (st_q == StOut) && (!ovalid_q || m_axis_tready);

  logic [15:0] ft;
  logic [7:0]  fcnt;
  assign ft   = cfg_q[RegTiming][47:32];
  assign fcnt = cfg_q[RegTiming][55:48];

  // tracking decision (combinational, in StTrk)
  logic trk_dv;
  logic [16:0] span_d, elap_d;
  logic        adv;
  logic [1:0]  ni;
  always_comb begin
    adv = age_q > tn;
    ni  = adv ? ti1 : ti_q;
    span_d = {1'b0, ktime(ni + 2'd1, ktimes)} - {1'b0, ktime(ni, ktimes)};
    elap_d = {1'b0, age_q} - {1'b0, ktime(ni, ktimes)};
    trk_dv = (trk_q ? spend_q : cpend_q) && !(adv && !({1'b0, tcnt} > {2'b00, ni} + 4'd1))
             && !(span_d[16] || span_d == 17'd0) && !(elap_d[16] || elap_d == 17'd0)
             && (elap_d < span_d);
  end

  always_comb begin
    div_req = '0;
    if (st_q == StFrDiv) begin
      div_req.start    = 1'b1;
      div_req.dividend = {16'h0, age_q};
      div_req.divisor  = ft;
    end else if (st_q == StTrk && (trk_q ? spend_q : cpend_q)) begin
      div_req.start    = 1'b0;
    end
    if (st_q == StTrk && trk_dv) begin
      div_req.start    = 1'b1;
      div_req.dividend = {elap_d[15:0], 16'h0};
      div_req.divisor  = span_d[15:0];
    end
  end

  logic [31:0] outcol;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle; step_q <= '0; trk_q <= 1'b0; ovalid_q <= 1'b0;
      age_q <= '0; avel_q <= '0; ang_q <= '0;
      for (int i = 0; i < 3; i++) begin vel_q[i] <= '0; pos_q[i] <= '0; end
      cidx_q <= '0; sidx_q <= '0; cpend_q <= 1'b0; spend_q <= 1'b0;
      ccol_q <= '0; csize_q <= '0; frame_q <= '0; alive_q <= 1'b0;
      ti_q <= '0; dt_q <= '0; fac_q <= '0; acc_q <= '0;
    end else begin
      if (out_load) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      case (st_q)
        StIdle: begin
          if (in_fire) begin
            dt_q <= s_axis_tdata[15:0];
            if (s_axis_tuser == OpStart) begin
              age_q <= '0;
              for (int i = 0; i < 3; i++) begin
                vel_q[i] <= cfg_q[RegStartMotion][16*i +: 16];
                pos_q[i] <= s_axis_tdata[16 + 16*i +: 16];
              end
              ang_q   <= cfg_q[RegStartMotion][63:48];
              avel_q  <= cfg_q[RegTiming][31:16];
              cidx_q  <= '0; sidx_q <= '0;
              cpend_q <= ccnt > 3'd1;
              spend_q <= scnt > 3'd1;
              ccol_q  <= cfg_q[RegColorLow][31:0];
              csize_q <= cfg_q[RegSizeKeys][15:0];
              frame_q <= '0;
              alive_q <= 1'b1;
              st_q    <= StOut;
            end else begin
              age_q <= age_d;
              if (age_d > cfg_q[RegTiming][15:0]) begin
                alive_q <= 1'b0;
                st_q    <= StOut;
              end else begin
                alive_q <= 1'b1;
                step_q  <= '0;
                st_q    <= StMul;
              end
            end
          end
        end
        StMul: begin
          case (step_q)
            4'd0, 4'd1, 4'd2: vel_q[step_q[1:0]] <= satv;
            4'd3: avel_q <= satv;
            4'd4, 4'd5, 4'd6: pos_q[step_q[1:0] - 2'd0] <= satv;
            default: ang_q <= fullsum[15:0];
          endcase
          step_q <= step_q + 4'd1;
          if (step_q == 4'd7) st_q <= StFrDiv;
        end
        StFrDiv: begin
          // divider started this cycle; its result is only awaited if needed
          if (!cfg_q[RegTiming][56] || fcnt == 8'd0 || ft == 16'd0) begin
            if (cfg_q[RegTiming][56]) frame_q <= (fcnt == 8'd0) ? 8'd0 : fcnt - 8'd1;
            trk_q <= 1'b0; ti_q <= cidx_q; st_q <= StTrk;
          end else begin
            st_q <= StFrWt;
          end
        end
        StFrWt: begin
          if (div_rsp.done) begin
            frame_q <= (div_rsp.quotient >= {24'h0, fcnt}) ? fcnt - 8'd1
                                                             : div_rsp.quotient[7:0];
            trk_q <= 1'b0; ti_q <= cidx_q; st_q <= StTrk;
          end
        end
        StTrk: begin
          if (!(trk_q ? spend_q : cpend_q)) begin
            if (trk_q) st_q <= StOut;
            else begin trk_q <= 1'b1; ti_q <= sidx_q; end
          end else begin
            ti_q <= ni;
            if (trk_q) sidx_q <= ni; else cidx_q <= ni;
            if (adv && !({1'b0, tcnt} > {2'b00, ni} + 4'd1)) begin
              if (trk_q) begin spend_q <= 1'b0; csize_q <= vb[15:0]; st_q <= StOut; end
              else begin
                cpend_q <= 1'b0; ccol_q <= vb; trk_q <= 1'b1; ti_q <= sidx_q;
              end
            end else begin
              step_q <= '0;
              if (trk_dv) st_q <= StDivWt;
              else begin
                // age at or before the last key gives 0, at or past the next key gives 1.0
                fac_q <= (span_d[16] || span_d == 17'd0 ||
                          (!elap_d[16] && !(elap_d < span_d))) ? 17'h10000 : 17'h0;
                st_q <= StBlend;
              end
            end
          end
        end
        StDivWt: begin
          if (div_rsp.done) begin
            fac_q <= div_rsp.quotient[16:0];
            st_q  <= StBlend;
          end
        end
        StBlend: begin
          if (trk_q) begin
            csize_q <= blendv[15:0];
            st_q <= StOut;
          end else begin
            acc_q[8*step_q[1:0] +: 8] <= blendv[7:0];
            step_q <= step_q + 4'd1;
            if (step_q == 4'd3) begin
              ccol_q <= {blendv[7:0], acc_q[23:0]};
              trk_q <= 1'b1; ti_q <= sidx_q; st_q <= StTrk;
            end
          end
        end
        StOut: begin
          if (out_load) st_q <= StIdle;
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign outcol = ccol_q;
  always_ff @(posedge clk_i) begin
    if (out_load)
      odata_q <= {7'h0, outcol, frame_q, csize_q, ang_q, pos_q[2], pos_q[1], pos_q[0],
                  alive_q};
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  ap_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> (st_q == StIdle)) else $error("ready outside idle");
  ap_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StOut) |=> ovalid_q) else $error("result lost");
  ap_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed while waiting");

endmodule

// ----- sv/pku_div.sv -----
// Shared restoring divider, one quotient bit a cycle.
module pku_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pku_pkg::div_req_t req_i,
  output pku_pkg::div_rsp_t rsp_o
);
  import pku_pkg::*;

  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [16:0] trial;
  logic [17:0] diff;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q[15:0], quo_q[31]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!diff[17]) begin
        rem_d = diff[16:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule
